// File: hdl/chb_pkg.sv
`default_nettype none

package chb_pkg;

  // input modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_SIGNED = 2'd1;
  localparam logic [1:0] MODE_INDEF  = 2'd2;

  // major types with special handling
  localparam logic [2:0] MAJOR_UINT   = 3'd0;
  localparam logic [2:0] MAJOR_NINT   = 3'd1;
  localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

  // additional information codes
  localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
  localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
  localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
  localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;
  localparam logic [4:0] AI_INDEF      = 5'd31;

  // argument byte counts
  localparam logic [3:0] LEN_ZERO  = 4'd0;
  localparam logic [3:0] LEN_ONE   = 4'd1;
  localparam logic [3:0] LEN_TWO   = 4'd2;
  localparam logic [3:0] LEN_FOUR  = 4'd4;
  localparam logic [3:0] LEN_EIGHT = 4'd8;

  // command queue between classifier and serializer
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one classified head, ready to serialize
  typedef struct packed {
    logic [7:0]  init_byte;
    logic [3:0]  nbytes;
    logic [63:0] arg;
    logic        rejected;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/cbor_head_encoder.sv
`default_nettype none

// CBOR head encoder: each accepted item (mode, major type, 64-bit argument,
// minimum argument length) becomes one CBOR head in preferred form, sent one
// byte per result item, initial byte first and argument bytes big endian, with
// out_last on the final byte. A reserved simple value is answered with a single
// zero byte flagged by out_rejected. Results come out at one byte per cycle
// while out_pop drains the output; an item is sent as 1 + n bytes, where n is
// 0, 1, 2, 4 or 8 argument bytes. A classifier register and a two-entry
// command queue sit ahead of the serializer, so new items are taken while
// earlier heads are still being sent; the first byte of a head passes the
// classifier register, the queue and the output register in that order.
module cbor_head_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [2:0]  in_major_type,
  input  wire logic [63:0] in_argument,
  input  wire logic [3:0]  in_min_len,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_rejected
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  chb_pkg::cmd_t push_cmd;
  chb_pkg::cmd_t head_cmd;

  // classify requests
  chb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_major_type (in_major_type),
    .in_argument   (in_argument),
    .in_min_len    (in_min_len),
    .q_push        (q_push),
    .q_cmd         (push_cmd),
    .q_full        (q_full)
  );

  // decouple classifier and serializer
  chb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // send head bytes
  chb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_cmd     (head_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_rejected (out_rejected)
  );

endmodule

`default_nettype wire

// File: hdl/chb_front.sv
`default_nettype none

module chb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic [1:0]    in_mode,
  input  wire logic [2:0]    in_major_type,
  input  wire logic [63:0]   in_argument,
  input  wire logic [3:0]    in_min_len,
  output logic               q_push,
  output chb_pkg::cmd_t      q_cmd,
  input  wire logic          q_full
);

  logic          valid_r;
  logic          valid_nxt;
  chb_pkg::cmd_t cmd_r;
  chb_pkg::cmd_t cmd_c;
  logic          accept;

  // classify the incoming request into a head command
  always_comb begin
    logic [2:0]  major;
    logic [63:0] arg;
    logic [3:0]  ml;
    logic        fits1;
    logic        fits2;
    logic        fits4;
    logic        arg_tiny;
    logic        reserved;
    major    = in_major_type;
    arg      = in_argument;
    ml       = (in_min_len > chb_pkg::LEN_EIGHT) ? chb_pkg::LEN_EIGHT : in_min_len;
    cmd_c    = '0;
    if (in_mode == chb_pkg::MODE_SIGNED) begin
      if (in_argument[63]) begin
        major = chb_pkg::MAJOR_NINT;
        arg   = ~in_argument;
      end else begin
        major = chb_pkg::MAJOR_UINT;
      end
    end
    fits1    = (arg[63:8] == '0);
    fits2    = (arg[63:16] == '0);
    fits4    = (arg[63:32] == '0);
    arg_tiny = (arg[63:5] == '0) && (arg[4:3] != 2'b11);
    // simple values 24..31 are reserved unless a float width is asked for
    reserved = (in_mode != chb_pkg::MODE_SIGNED) && (major == chb_pkg::MAJOR_SIMPLE) &&
               (arg[63:5] == '0) && (arg[4:3] == 2'b11) && (in_min_len == chb_pkg::LEN_ZERO);
    cmd_c.arg = arg;
    if (in_mode == chb_pkg::MODE_INDEF) begin
      cmd_c.init_byte = {major, chb_pkg::AI_INDEF};
      cmd_c.nbytes    = chb_pkg::LEN_ZERO;
    end else if (reserved) begin
      cmd_c.init_byte = '0;
      cmd_c.nbytes    = chb_pkg::LEN_ZERO;
      cmd_c.rejected  = 1'b1;
    end else if (arg_tiny && (ml == chb_pkg::LEN_ZERO)) begin
      cmd_c.init_byte = {major, arg[4:0]};
      cmd_c.nbytes    = chb_pkg::LEN_ZERO;
    end else if ((ml <= chb_pkg::LEN_ONE) && fits1) begin
      cmd_c.init_byte = {major, chb_pkg::AI_ONE_BYTE};
      cmd_c.nbytes    = chb_pkg::LEN_ONE;
    end else if ((ml <= chb_pkg::LEN_TWO) && fits2) begin
      cmd_c.init_byte = {major, chb_pkg::AI_TWO_BYTE};
      cmd_c.nbytes    = chb_pkg::LEN_TWO;
    end else if ((ml <= chb_pkg::LEN_FOUR) && fits4) begin
      cmd_c.init_byte = {major, chb_pkg::AI_FOUR_BYTE};
      cmd_c.nbytes    = chb_pkg::LEN_FOUR;
    end else begin
      cmd_c.init_byte = {major, chb_pkg::AI_EIGHT_BYTE};
      cmd_c.nbytes    = chb_pkg::LEN_EIGHT;
    end
  end

  // input stage handshake
  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r && !q_full;
  assign q_cmd   = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_c;
    end
  end

endmodule

`default_nettype wire

// File: hdl/chb_queue.sv
`default_nettype none

module chb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire chb_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output chb_pkg::cmd_t      head_cmd,
  output logic               empty
);

  chb_pkg::cmd_t                  mem_r [chb_pkg::Q_DEPTH];
  logic [chb_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [chb_pkg::Q_PTR_W-1:0]    wr_ptr_nxt;
  logic [chb_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [chb_pkg::Q_PTR_W-1:0]    rd_ptr_nxt;
  logic [chb_pkg::Q_CNT_W-1:0]    count_r;
  logic [chb_pkg::Q_CNT_W-1:0]    count_nxt;

  assign full     = (count_r == chb_pkg::Q_CNT_W'(chb_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == chb_pkg::Q_PTR_W'(chb_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == chb_pkg::Q_PTR_W'(chb_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  // fill count never goes past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= chb_pkg::Q_CNT_W'(chb_pkg::Q_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

// File: hdl/chb_back.sv
`default_nettype none

module chb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire chb_pkg::cmd_t head_cmd,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_rejected
);

  logic [3:0] k_r;
  logic [3:0] k_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       rej_r;
  logic       take;
  logic       is_last;
  logic [3:0] remain;
  logic [2:0] sel;
  logic [7:0] byte_c;

  // pick the next head byte: initial byte, then argument high byte first
  assign is_last = (k_r == head_cmd.nbytes);
  assign remain  = head_cmd.nbytes - k_r;
  assign sel     = remain[2:0];
  assign byte_c  = (k_r == chb_pkg::LEN_ZERO) ? head_cmd.init_byte :
                   head_cmd.arg[{sel, 3'b000} +: 8];

  // output register loads when empty or being drained
  assign take  = !q_empty && (!out_valid_r || out_pop);
  assign q_pop = take && is_last;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      k_nxt         = is_last ? '0 : k_r + 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= byte_c;
      last_r <= is_last;
      rej_r  <= head_cmd.rejected;
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_byte     = byte_r;
  assign out_last     = last_r;
  assign out_rejected = rej_r;

`ifndef SYNTHESIS
  // a refused item is a single zero byte
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (last_r && (byte_r == '0)))
    else $error("rejected item not a single zero byte");

  // mid-head position only while a head is at the queue front
  a_pos_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> !q_empty)
    else $error("byte position set with no head queued");

  // position never passes the head's argument length
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (k_r <= head_cmd.nbytes))
    else $error("byte position beyond head length");
`endif

endmodule

`default_nettype wire
